>>> design/rfss_pkg.sv
// Package for the reciprocal frequency seven-segment block: field widths,
// register reset values, register indexes and the segment decoder.
// No dependencies.
`default_nettype none

package rfss_pkg;

  localparam int DIVIDEND_W = 27;
  localparam int COUNT_W    = 16;
  localparam int FREQ_W     = 14;
  localparam int SEG_W      = 8;
  localparam int SEL_W      = 4;
  localparam int DIGIT_W    = 4;
  localparam int CFG_W      = DIVIDEND_W;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

  localparam int DIGIT_COUNT_DEFAULT = 4;
  localparam int DIGIT_MAX           = 4;

  localparam logic [DIVIDEND_W-1:0] DIVIDEND_RESET = DIVIDEND_W'(100000000);
  localparam logic [COUNT_W-1:0]    MINIMUM_RESET  = COUNT_W'(10000);

  typedef enum logic [0:0] {
    CFG_DIVIDEND = 1'b0,
    CFG_MINIMUM  = 1'b1
  } cfg_index_t;

  function automatic int pow10(input int n);
    int p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  // Common-cathode pattern, with segments 3-6 moved up one bit for the port.
  function automatic logic [SEG_W-1:0] seg_port(input logic [DIGIT_W-1:0] d);
    logic [6:0] pat;
    unique case (d)
      4'd0:    pat = 7'h3F;
      4'd1:    pat = 7'h06;
      4'd2:    pat = 7'h5B;
      4'd3:    pat = 7'h4F;
      4'd4:    pat = 7'h66;
      4'd5:    pat = 7'h6D;
      4'd6:    pat = 7'h7D;
      4'd7:    pat = 7'h07;
      4'd8:    pat = 7'h7F;
      4'd9:    pat = 7'h6F;
      default: pat = 7'h00;
    endcase
    return {pat[6:3], 1'b0, pat[2:0]};
  endfunction

endpackage

`default_nettype wire

>>> design/reciprocal_frequency_seven_segment.sv
// Top level of the reciprocal frequency counter with seven-segment output.
// Depends on rfss_pkg for widths, reset values and the segment decoder.
//
// Usage:
//   Slave stream: s_tdata[15:0] is the captured period count, s_tuser is the
//   capture flag. Each accepted word yields DIGIT_COUNT (at most four) master
//   words, most significant digit first, with m_tlast on the units digit.
//   The shown frequency is frequency_dividend / period_count, saturated to
//   the largest value the digits hold, and zero without a capture or for a
//   period below the configured minimum.
//   Pipeline: input register, saturation check, a restoring divider that
//   settles two quotient bits per stage, a frequency stage, one stage per
//   decimal digit and an output serializer.
//   Throughput: a slave word can enter every cycle while the pipeline has
//   room; sustained, the rate is set by the single master channel that
//   carries one word per digit.
//   Stalls: when the master side stalls, the whole pipeline holds and
//   s_tready drops once the last stage is full; nothing is lost or repeated.
//   Reset clears all valid bits and loads the register defaults.
`default_nettype none

module reciprocal_frequency_seven_segment
  import rfss_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [0:0]            cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // s_tdata: period_count [15:0]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // s_tuser: capture_seen [0]
  input  wire logic                  s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // m_tdata: segment_port_byte [7:0], digit_enable [11:8],
  //          shown_frequency [25:12], zero fill [31:26]
  output logic [OUT_DATA_W-1:0]      m_tdata,
  output logic                       m_tlast
);

  localparam int DIGITS = (DIGIT_COUNT > DIGIT_MAX) ? DIGIT_MAX :
                          ((DIGIT_COUNT < 1) ? 1 : DIGIT_COUNT);
  localparam int SPAN   = pow10(DIGITS);
  localparam int LIMIT  = SPAN - 1;
  localparam int QW     = $clog2(SPAN);
  localparam int CW     = (DIVIDEND_W > COUNT_W + QW) ? DIVIDEND_W : COUNT_W + QW;
  localparam int STEPS  = 2;
  localparam int NSTG   = (QW + STEPS - 1) / STEPS;
  localparam int IW     = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int DV_W   = DIGITS * DIGIT_W;

  // Configuration registers.
  logic [DIVIDEND_W-1:0] frequency_dividend;
  logic [COUNT_W-1:0]    minimum_period_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      frequency_dividend   <= DIVIDEND_RESET;
      minimum_period_count <= MINIMUM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_DIVIDEND: frequency_dividend   <= cfg_data[DIVIDEND_W-1:0];
        CFG_MINIMUM:  minimum_period_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic load_ok;

  // Stage 1: input register and the saturation product.
  logic                  v1;
  logic [COUNT_W-1:0]    cnt1;
  logic [DIVIDEND_W-1:0] dvd1;
  logic                  zero1;
  logic [CW-1:0]         prod1;
  logic [COUNT_W-1:0]    in_count;

  assign in_count = s_tdata[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
    if (en) begin
      cnt1  <= in_count;
      dvd1  <= frequency_dividend;
      zero1 <= !(s_tuser && (in_count != '0) && (in_count >= minimum_period_count));
      prod1 <= CW'(in_count) * CW'(SPAN);
    end
  end

  // Stage 2 and divider stages. Index 0 is the saturation check stage.
  logic              v_p   [0:NSTG];
  logic [CW-1:0]     rem_p [0:NSTG];
  logic [QW-1:0]     quo_p [0:NSTG];
  logic [COUNT_W-1:0] cnt_p [0:NSTG];
  logic              zero_p[0:NSTG];
  logic              sat_p [0:NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p[0] <= 1'b0;
    end else if (en) begin
      v_p[0] <= v1;
    end
    if (en) begin
      rem_p[0]  <= CW'(dvd1);
      quo_p[0]  <= '0;
      cnt_p[0]  <= cnt1;
      zero_p[0] <= zero1;
      // A quotient that reaches SPAN saturates, so QW quotient bits suffice.
      sat_p[0]  <= (CW'(dvd1) >= prod1);
    end
  end

  for (genvar s = 1; s <= NSTG; s++) begin : g_div
    logic [CW-1:0] rem_next;
    logic [QW-1:0] quo_next;

    always_comb begin
      logic [CW-1:0] sub;
      int            k;
      rem_next = rem_p[s-1];
      quo_next = quo_p[s-1];
      sub      = '0;
      for (int j = 0; j < STEPS; j++) begin
        k = QW - 1 - ((s - 1) * STEPS + j);
        if (k >= 0) begin
          sub = CW'(cnt_p[s-1]) << k;
          if (rem_next >= sub) begin
            rem_next    = rem_next - sub;
            quo_next[k] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_p[s] <= 1'b0;
      end else if (en) begin
        v_p[s] <= v_p[s-1];
      end
      if (en) begin
        rem_p[s]  <= rem_next;
        quo_p[s]  <= quo_next;
        cnt_p[s]  <= cnt_p[s-1];
        zero_p[s] <= zero_p[s-1];
        sat_p[s]  <= sat_p[s-1];
      end
    end
  end

  // Frequency stage and one stage per decimal digit.
  logic            v_d   [0:DIGITS];
  logic [QW-1:0]   freq_d[0:DIGITS];
  logic [QW-1:0]   rest_d[0:DIGITS];
  logic [DV_W-1:0] dig_d [0:DIGITS];
  logic [QW-1:0]   freq_sel;

  always_comb begin
    if (zero_p[NSTG]) begin
      freq_sel = '0;
    end else if (sat_p[NSTG]) begin
      freq_sel = QW'(LIMIT);
    end else begin
      freq_sel = quo_p[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_d[0] <= 1'b0;
    end else if (en) begin
      v_d[0] <= v_p[NSTG];
    end
    if (en) begin
      freq_d[0] <= freq_sel;
      rest_d[0] <= freq_sel;
      dig_d[0]  <= '0;
    end
  end

  for (genvar d = 1; d <= DIGITS; d++) begin : g_dig
    localparam int WEIGHT = pow10(DIGITS - d);
    logic [QW-1:0]      rest_next;
    logic [DIGIT_W-1:0] digit;
    logic [DV_W-1:0]    dig_next;

    // The remainder is below ten times the weight, so four steps give 0..9.
    always_comb begin
      logic [QW+DIGIT_W-1:0] r;
      logic [QW+DIGIT_W-1:0] w;
      r     = (QW + DIGIT_W)'(rest_d[d-1]);
      digit = '0;
      for (int b = DIGIT_W - 1; b >= 0; b--) begin
        w = (QW + DIGIT_W)'(WEIGHT) << b;
        if (r >= w) begin
          r        = r - w;
          digit[b] = 1'b1;
        end
      end
      rest_next = r[QW-1:0];
      dig_next  = dig_d[d-1];
      dig_next[(d-1)*DIGIT_W +: DIGIT_W] = digit;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_d[d] <= 1'b0;
      end else if (en) begin
        v_d[d] <= v_d[d-1];
      end
      if (en) begin
        freq_d[d] <= freq_d[d-1];
        rest_d[d] <= rest_next;
        dig_d[d]  <= dig_next;
      end
    end
  end

  // Output serializer: one master word per digit.
  logic            ser_valid;
  logic [IW-1:0]   idx;
  logic [QW-1:0]   ser_freq;
  logic [DV_W-1:0] ser_dig;
  logic            ser_last;

  assign ser_last = (idx == IW'(DIGITS - 1));
  assign load_ok  = !ser_valid || (m_tready && ser_last);
  assign en       = !v_d[DIGITS] || load_ok;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      idx       <= '0;
    end else if (load_ok) begin
      ser_valid <= v_d[DIGITS];
      idx       <= '0;
    end else if (m_tready) begin
      idx <= idx + 1'b1;
    end
    if (load_ok) begin
      ser_freq <= freq_d[DIGITS];
      ser_dig  <= dig_d[DIGITS];
    end
  end

  logic [DIGIT_W-1:0] cur_digit;
  logic [SEL_W-1:0]   cur_sel;

  assign cur_digit = ser_dig[idx*DIGIT_W +: DIGIT_W];
  assign cur_sel   = SEL_W'(1) << idx;

  assign m_tvalid = ser_valid;
  assign m_tlast  = ser_last;
  assign m_tdata  = {(OUT_DATA_W - SEG_W - SEL_W - FREQ_W)'(0), FREQ_W'(ser_freq),
                     cur_sel, seg_port(cur_digit)};

endmodule

`default_nettype wire
